@@ rtl/core/spn48_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package spn48_pkg;

    // Block geometry and round structure.
    localparam int BLK_W   = 48;
    localparam int NIB_W   = 4;
    localparam int NUM_NIB = BLK_W / NIB_W;
    localparam int ROT_AMT = 11;
    localparam int ROUNDS  = 32;

    typedef logic [BLK_W-1:0] block_t;
    typedef logic [NIB_W-1:0] nibble_t;

    // Inverse substitution box, indexed by the incoming nibble.
    localparam nibble_t INV_SBOX [16] = '{
        4'd11, 4'd4,  4'd6,  4'd15, 4'd3,  4'd8,  4'd12, 4'd1,
        4'd2,  4'd5,  4'd9,  4'd10, 4'd13, 4'd14, 4'd0,  4'd7
    };

    // One decryption round: rotate right, substitute every nibble, add the key.
    function automatic block_t dec_round(input block_t blk, input block_t key);
        block_t rot;
        block_t sub;
        rot = {blk[ROT_AMT-1:0], blk[BLK_W-1:ROT_AMT]};
        for (int n = 0; n < NUM_NIB; n++)
        begin
            sub[n*NIB_W +: NIB_W] = INV_SBOX[rot[n*NIB_W +: NIB_W]];
        end
        return sub ^ key;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/spn48_block_decrypt.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Each accepted beat passes through one register stage per round to its result.
// Throughput: one block per cycle while the output is taken; each register stage holds one round.
// A full pipeline stalls only when the last stage's result is not taken.
// Reset clears every stage valid bit and sets the key register to zero.

module spn48_block_decrypt
    import spn48_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   cipher_key_we,
    input  wire block_t cipher_key,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  wire block_t cipher_block,
    output logic        out_valid,
    input  wire logic   out_ready,
    output block_t      plain_block
);

    block_t            key_reg;
    logic [ROUNDS:0]   link_valid;
    logic [ROUNDS:0]   link_ready;
    block_t            link_block [ROUNDS+1];

    // Key register; the user must write it only while the pipeline is idle, the block itself does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cipher_key_we)
        begin
            key_reg <= cipher_key;
        end
    end

    // Pipeline ends.
    assign link_valid[0]      = in_valid;
    assign link_block[0]      = cipher_block;
    assign in_ready           = link_ready[0];
    assign link_ready[ROUNDS] = out_ready;
    assign out_valid          = link_valid[ROUNDS];
    assign plain_block        = link_block[ROUNDS];

    // One register stage per round.
    for (genvar i = 0; i < ROUNDS; i++)
    begin : g_round
        spn48_round u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .key       (key_reg),
            .in_valid  (link_valid[i]),
            .in_ready  (link_ready[i]),
            .in_block  (link_block[i]),
            .out_valid (link_valid[i+1]),
            .out_ready (link_ready[i+1]),
            .out_block (link_block[i+1])
        );
    end

`ifndef NO_ASSERTIONS
    // The input side is held off only when every stage is occupied.
    a_stall_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        !in_ready |-> (&link_valid[ROUNDS:1])
    ) else $error("input stalled while a stage is empty");

    // Beats in flight change only by beats accepted and results taken.
    a_occupancy: assert property (
        @(posedge clk) disable iff (!rst_n)
        1'b1 |=> ($countones(link_valid[ROUNDS:1]) ==
                  $past($countones(link_valid[ROUNDS:1]))
                  + $past(in_valid && in_ready) - $past(out_valid && out_ready))
    ) else $error("beat lost or duplicated in the pipeline");
`endif

endmodule

`default_nettype wire

@@ rtl/core/spn48_round.sv @@
`timescale 1ns / 1ps
`default_nettype none

module spn48_round
    import spn48_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire block_t key,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  wire block_t in_block,
    output logic        out_valid,
    input  wire logic   out_ready,
    output block_t      out_block
);

    logic   valid_reg;
    logic   valid_next;
    block_t block_reg;
    block_t block_next;

    // The stage takes a beat when it is empty or its content moves on,
    // so bubbles are squeezed out of the pipeline.
    assign in_ready = !valid_reg || out_ready;

    // Next values: compute one round on the beat entering this stage.
    always_comb
    begin
        valid_next = valid_reg;
        block_next = block_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
            if (in_valid)
            begin
                block_next = dec_round(in_block, key);
            end
        end
    end

    // Valid bit is reset; the payload register needs none.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        block_reg <= block_next;
    end

    assign out_valid = valid_reg;
    assign out_block = block_reg;

endmodule

`default_nettype wire
